FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define URS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define URS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/urs_pkg.sv
`timescale 1ns / 1ps

package urs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH   = 256;
    localparam int ELEMENT_WIDTH = 16;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);

    // Item field widths
    localparam int IDX_W  = 8;
    localparam int ELEM_W = 16;
    localparam int WORD_W = 64;
    localparam int CNT_W  = 9;

    // Divider: two restoring steps per cycle
    localparam int DIV_STEPS = WORD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_WORD = 2'd1,
        ACT_READ = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_THRESH,
        ST_DRAW,
        ST_RD_POS,
        ST_RD_DRAW,
        ST_WR_POS,
        ST_WR_DRAW,
        ST_RD_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        action_t             action;
        logic [IDX_W-1:0]    index;
        logic [ELEM_W-1:0]   element;
        logic [WORD_W-1:0]   random_word;
    } req_t;

    typedef struct packed {
        logic [ELEM_W-1:0]   read_element;
        logic                word_used;
        logic [IDX_W-1:0]    drawn_index;
        logic [IDX_W-1:0]    swap_position;
        logic                shuffle_done;
    } rsp_t;

endpackage

FILE: src/unbiased_random_shuffle.sv
`timescale 1ns / 1ps

// Fisher-Yates shuffle of an on-chip element table with unbiased draws.
// Request channel (req_valid / req_stall / req): a load writes one element
// and restarts the shuffle, a random-word item performs one shuffle step,
// a read returns one element. Response channel (rsp_valid / rsp_stall / rsp)
// carries exactly one result item per request item, in order.
// The APB port holds element_count at byte address 0; pready is tied high.
// A load or an ignored word goes straight to the result state; a read first
// waits for the registered table read. A random word with a step to do finds
// the threshold (2^64 mod r), then the draw (word mod r) on the same shared
// two-bit-per-cycle remainder unit, then reads both entries, writes them
// back swapped and hands over the result. A rejected word ends after the
// threshold pass. One item is in work at a time; req_stall is high meanwhile.
// The result sits in an output register, so a new item is taken while the
// previous result is still stalled; a finished item waits for that register.
// Reset clears the remaining count (shuffle done), sets element_count to 256
// and empties the output register; table contents are undefined until loaded.
module unbiased_random_shuffle
    import urs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    // response channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    state_t                     state_reg, state_next;
    req_t                       req_reg;
    rsp_t                       res_reg;
    rsp_t                       res_out;
    rsp_t                       rsp_reg;
    logic                       rsp_valid_reg;
    logic [CNT_W-1:0]           remaining_reg;
    logic [CNT_W-1:0]           element_count_reg;

    logic [WORD_W-1:0]          dvd_reg;
    logic [CNT_W-1:0]           rem_reg;
    logic [DIV_CNT_W-1:0]       cnt_reg;
    logic [ELEMENT_WIDTH-1:0]   tmp_reg;

    logic [ELEMENT_WIDTH-1:0]   store_reg [TABLE_DEPTH];
    logic [ELEMENT_WIDTH-1:0]   rdata_reg;

    logic                       accept;
    logic                       rsp_free;
    logic                       cfg_wr;
    logic [CNT_W-1:0]           start_cnt;
    logic [CNT_W-1:0]           pos_full;
    logic [ADDR_W-1:0]          pos_addr;
    logic [ADDR_W-1:0]          draw_addr;
    logic                       req_in_table;
    logic                       held_in_table;

    logic [CNT_W:0]             div_den;
    logic [CNT_W:0]             div_t1, div_r1, div_t2, div_r2;
    logic [CNT_W-1:0]           rem_step;
    logic                       div_last;
    logic                       word_ok;

    logic                       div_load_thr;
    logic                       div_load_word;
    logic                       div_run;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [ELEMENT_WIDTH-1:0]   mem_wdata;

    // Handshake helpers
    assign accept   = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign cfg_wr   = psel && penable && pwrite;

    // Shuffle bookkeeping
    assign start_cnt = (element_count_reg > CNT_W'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : element_count_reg;
    assign pos_full  = remaining_reg - CNT_W'(1);
    assign pos_addr  = pos_full[ADDR_W-1:0];
    assign draw_addr = ADDR_W'(res_reg.drawn_index);
    assign req_in_table  = 32'(req.index) < 32'(TABLE_DEPTH);
    assign held_in_table = 32'(req_reg.index) < 32'(TABLE_DEPTH);

    // Shared remainder unit: two restoring steps per cycle, divisor = remaining
    always_comb
    begin
        div_den  = {1'b0, remaining_reg};
        div_t1   = {rem_reg, dvd_reg[WORD_W-1]};
        div_r1   = (div_t1 >= div_den) ? (div_t1 - div_den) : div_t1;
        div_t2   = {div_r1[CNT_W-1:0], dvd_reg[WORD_W-2]};
        div_r2   = (div_t2 >= div_den) ? (div_t2 - div_den) : div_t2;
        rem_step = div_r2[CNT_W-1:0];
    end

    assign div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign word_ok  = req_reg.random_word >= WORD_W'(rem_step);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        ACT_LOAD: state_next = ST_RESULT;
                        ACT_WORD: state_next = (remaining_reg > CNT_W'(1)) ?
                                               ST_THRESH : ST_RESULT;
                        ACT_READ: state_next = ST_RD_WAIT;
                        default:  state_next = ST_RESULT;
                    endcase
                end
            end
            ST_THRESH:
            begin
                if (div_last)
                    state_next = word_ok ? ST_DRAW : ST_RESULT;
            end
            ST_DRAW:
            begin
                if (div_last)
                    state_next = ST_RD_POS;
            end
            ST_RD_POS:  state_next = ST_RD_DRAW;
            ST_RD_DRAW: state_next = ST_WR_POS;
            ST_WR_POS:  state_next = ST_WR_DRAW;
            ST_WR_DRAW: state_next = ST_RESULT;
            ST_RD_WAIT: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        req_stall     = (state_reg != ST_IDLE);
        div_load_thr  = 1'b0;
        div_load_word = 1'b0;
        div_run       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = pos_addr;
        mem_wdata     = rdata_reg;
        mem_raddr     = pos_addr;
        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr    = ADDR_W'(req.index);
                mem_waddr    = ADDR_W'(req.index);
                mem_wdata    = ELEMENT_WIDTH'(req.element);
                mem_we       = accept && (req.action == ACT_LOAD) && req_in_table;
                div_load_thr = accept && (state_next == ST_THRESH);
            end
            ST_THRESH:
            begin
                div_run       = 1'b1;
                div_load_word = div_last && word_ok;
            end
            ST_DRAW:    div_run   = 1'b1;
            ST_RD_POS:  mem_raddr = pos_addr;
            ST_RD_DRAW: mem_raddr = draw_addr;
            ST_WR_POS:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_addr;
                mem_wdata = rdata_reg;
            end
            ST_WR_DRAW:
            begin
                mem_we    = 1'b1;
                mem_waddr = draw_addr;
                mem_wdata = tmp_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Element table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_reg[mem_waddr] <= mem_wdata;
        rdata_reg <= store_reg[mem_raddr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            remaining_reg     <= '0;
            element_count_reg <= CNT_W'(256);
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr && (paddr[CFG_ADDR_W-1] == REG_ELEMENT_COUNT))
                element_count_reg <= pwdata[CNT_W-1:0];

            // load restarts the shuffle; a completed exchange shrinks it
            if (state_reg == ST_IDLE && accept && req.action == ACT_LOAD)
                remaining_reg <= start_cnt;
            else if (state_reg == ST_WR_DRAW)
                remaining_reg <= pos_full;

            if (state_reg == ST_RESULT && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Finished result with the current shuffle state
    always_comb
    begin
        res_out              = res_reg;
        res_out.shuffle_done = (remaining_reg <= CNT_W'(1));
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
            res_reg <= '0;
        end

        // divider sequencing
        if (div_load_thr)
        begin
            dvd_reg <= '0 - WORD_W'(remaining_reg);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (div_load_word)
        begin
            dvd_reg <= req_reg.random_word;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (div_run)
        begin
            dvd_reg <= {dvd_reg[WORD_W-3:0], 2'b00};
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end

        // draw finished: record the exchange
        if (state_reg == ST_DRAW && div_last)
        begin
            res_reg.word_used     <= 1'b1;
            res_reg.drawn_index   <= IDX_W'(rem_step);
            res_reg.swap_position <= IDX_W'(pos_full);
        end

        // element at the swap position, held for the second write
        if (state_reg == ST_RD_DRAW)
            tmp_reg <= rdata_reg;

        if (state_reg == ST_RD_WAIT && held_in_table)
            res_reg.read_element <= ELEM_W'(rdata_reg);

        // hand the result to the output register
        if (state_reg == ST_RESULT && rsp_free)
            rsp_reg <= res_out;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Register read-back
    assign prdata = (paddr[CFG_ADDR_W-1] == REG_ELEMENT_COUNT) ?
                    CFG_DATA_W'(element_count_reg) : '0;
    assign pready = 1'b1;

endmodule

FILE: src/urs_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module urs_checker
    import urs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // one item in work at a time: a taken item blocks the next cycle
    `URS_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

    // a stalled result holds
    `URS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // a draw always lies at or below the swap position
    `URS_ASSERT_NOW(a_draw_in_range, rsp_valid && rsp.word_used,
                    rsp.drawn_index <= rsp.swap_position)

    // no exchange reported means no positions reported
    `URS_ASSERT_NOW(a_unused_zero, rsp_valid && !rsp.word_used,
                    rsp.drawn_index == '0 && rsp.swap_position == '0)

endmodule

bind unbiased_random_shuffle urs_checker u_urs_checker (.*);
